// ----- src/gbts_pkg.sv -----
// Shared constants, codes and control types for the gap buffer text store.
// No dependencies; every other file imports this package.
package gbts_pkg;

	// Storage geometry
	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);

	// Field widths of the command and response beats
	localparam int CMD_W  = 3;
	localparam int CHAR_W = 8;
	localparam int POS_W  = 11;
	localparam int ST_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT    = 3'd0,
		CMD_BACKSPACE = 3'd1,
		CMD_DELETE    = 3'd2,
		CMD_MOVE      = 3'd3,
		CMD_READ      = 3'd4
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_CLAMPED = 3'd3,
		ST_RANGE   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic ready;     // take a command beat
		logic capture;   // latch the accepted beat
		logic edit;      // apply insert/backspace/delete and load the response
		logic setup;     // resolve move target or issue read lookup
		logic shift_rd;  // fetch the byte that crosses the gap
		logic shift_wr;  // store it on the far side and step the gap
		logic respond;   // load the response of a move or read
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             out_free;
		logic             move_none;
		logic             shift_last;
	} sts_t;

endpackage

// ----- src/gbts_if.sv -----
// Valid/ready channel interfaces for command and response beats.
// Depends on gbts_pkg for field widths.
interface gbts_in_if import gbts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [CHAR_W-1:0] char_in;
	logic [POS_W-1:0]  position;

	modport source (output valid, output cmd, output char_in, output position, input ready);
	modport sink   (input valid, input cmd, input char_in, input position, output ready);
endinterface

interface gbts_out_if import gbts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] char_out;
	logic [POS_W-1:0]  cursor;
	logic [POS_W-1:0]  text_length;
	logic [ST_W-1:0]   status;

	modport source (output valid, output char_out, output cursor, output text_length,
		output status, input ready);
	modport sink   (input valid, input char_out, input cursor, input text_length,
		input status, output ready);
endinterface

// ----- src/gbts_ctrl.sv -----
// Command sequencer for the gap buffer text store.
// Depends on gbts_pkg; drives ctl_t commands into gbts_dp, reads sts_t back.
module gbts_ctrl import gbts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t state_q;
	state_t state_n;
	cmd_t   op;

	assign op = cmd_t'(sts.op);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_n = S_EXEC;
				end
			end
			S_EXEC: begin
				priority if (op == CMD_MOVE) begin
					state_n = sts.move_none ? S_RESP : S_SHIFT_RD;
				end else if (op == CMD_READ) begin
					state_n = S_RESP;
				end else if (sts.out_free) begin
					state_n = S_IDLE;
				end
			end
			S_SHIFT_RD: state_n = S_SHIFT_WR;
			S_SHIFT_WR: state_n = sts.shift_last ? S_RESP : S_SHIFT_RD;
			S_RESP: begin
				if (sts.out_free) begin
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_IDLE: begin
				ctl.ready   = 1'b1;
				ctl.capture = req_valid;
			end
			S_EXEC: begin
				priority if (op == CMD_MOVE || op == CMD_READ) begin
					ctl.setup = 1'b1;
				end else begin
					ctl.edit = sts.out_free;
				end
			end
			S_SHIFT_RD: ctl.shift_rd = 1'b1;
			S_SHIFT_WR: ctl.shift_wr = 1'b1;
			S_RESP:     ctl.respond  = sts.out_free;
			default:    ctl = '0;
		endcase
	end

`ifndef SYNTHESIS
	// A response is loaded only into a free output slot
	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.edit || ctl.respond) |-> sts.out_free)
		else $error("response loaded into busy output slot");

	// Every byte fetch is followed by its store
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_rd |=> ctl.shift_wr)
		else $error("gap shift fetch without store");

	// A captured command always moves the sequencer into S_EXEC
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q == S_EXEC))
		else $error("captured command not executed");
`endif

endmodule

// ----- src/gbts_dp.sv -----
// Datapath: text memory, gap pointers, command latch and response register.
// Depends on gbts_pkg and gbts_if; controlled by gbts_ctrl via ctl_t/sts_t.
module gbts_dp import gbts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  ctl_t        ctl,
	output sts_t        sts,
	gbts_in_if.sink     req,
	gbts_out_if.source  rsp
);

	localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);
	localparam logic [POS_W-1:0] ONE     = POS_W'(1);

	logic [CHAR_W-1:0] mem [CAPACITY];
	logic [CHAR_W-1:0] rdata_q;

	// Latched command beat
	logic [CMD_W-1:0]  op_q;
	logic [CHAR_W-1:0] ch_q;
	logic [POS_W-1:0]  pos_q;

	// Gap pointers and move/read context
	logic [POS_W-1:0]  gs_q;
	logic [POS_W-1:0]  ge_q;
	logic [POS_W-1:0]  tgt_q;
	status_t           st_q;
	logic              rdok_q;

	// Response register
	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic [POS_W-1:0]  out_cursor_q;
	logic [POS_W-1:0]  out_len_q;
	status_t           out_status_q;

	logic [POS_W-1:0]  len;
	logic [POS_W-1:0]  tgt_c;
	logic              clamp_c;
	logic              range_c;
	logic [POS_W-1:0]  rd_phys;
	logic              left;
	logic [POS_W-1:0]  gs_n;
	logic [POS_W-1:0]  ge_n;
	status_t           st_n;
	logic              ins_we;
	logic              we;
	logic [POS_W-1:0]  waddr;
	logic [CHAR_W-1:0] wdata;
	logic              re;
	logic [POS_W-1:0]  raddr;
	logic              out_free;
	cmd_t              op;

	assign op       = cmd_t'(op_q);
	assign len      = CAP_POS - (ge_q - gs_q);
	assign out_free = !out_valid_q || rsp.ready;

	// Move target clamp and read range check
	assign clamp_c = pos_q > len;
	assign tgt_c   = clamp_c ? len : pos_q;
	assign range_c = pos_q >= len;
	assign rd_phys = (pos_q < gs_q) ? pos_q : pos_q + (ge_q - gs_q);
	assign left    = tgt_q < gs_q;

	assign sts.op         = op_q;
	assign sts.out_free   = out_free;
	assign sts.move_none  = tgt_c == gs_q;
	assign sts.shift_last = left ? ((gs_q - ONE) == tgt_q) : ((gs_q + ONE) == tgt_q);

	// Edit outcome
	always_comb begin
		gs_n   = gs_q;
		ge_n   = ge_q;
		st_n   = ST_OK;
		ins_we = 1'b0;
		unique case (op)
			CMD_INSERT: begin
				if (gs_q == ge_q) begin
					st_n = ST_FULL;
				end else begin
					gs_n   = gs_q + ONE;
					ins_we = 1'b1;
				end
			end
			CMD_BACKSPACE: begin
				if (gs_q == '0) begin
					st_n = ST_EMPTY;
				end else begin
					gs_n = gs_q - ONE;
				end
			end
			CMD_DELETE: begin
				if (ge_q == CAP_POS) begin
					st_n = ST_EMPTY;
				end else begin
					ge_n = ge_q + ONE;
				end
			end
			default: st_n = ST_OK;
		endcase
	end

	// Memory port steering
	assign we    = (ctl.edit && ins_we) || ctl.shift_wr;
	assign waddr = ctl.shift_wr ? (left ? (ge_q - ONE) : gs_q) : gs_q;
	assign wdata = ctl.shift_wr ? rdata_q : ch_q;
	assign re    = (ctl.setup && op == CMD_READ) || ctl.shift_rd;
	assign raddr = ctl.shift_rd ? (left ? (gs_q - ONE) : ge_q) : rd_phys;

	// Text memory, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr[ADDR_W-1:0]] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr[ADDR_W-1:0]];
		end
	end

	// Latch the command beat
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_q  <= req.cmd;
			ch_q  <= req.char_in;
			pos_q <= req.position;
		end
	end

	// Gap pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gs_q <= '0;
			ge_q <= CAP_POS;
		end else if (ctl.edit) begin
			gs_q <= gs_n;
			ge_q <= ge_n;
		end else if (ctl.shift_wr) begin
			gs_q <= left ? gs_q - ONE : gs_q + ONE;
			ge_q <= left ? ge_q - ONE : ge_q + ONE;
		end
	end

	// Hold move target and status across the shift
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			if (op == CMD_MOVE) begin
				tgt_q  <= tgt_c;
				st_q   <= clamp_c ? ST_CLAMPED : ST_OK;
				rdok_q <= 1'b0;
			end else begin
				st_q   <= range_c ? ST_RANGE : ST_OK;
				rdok_q <= !range_c;
			end
		end
	end

	// Response valid: set on load, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.edit || ctl.respond) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (ctl.edit) begin
			out_char_q   <= '0;
			out_cursor_q <= gs_n;
			out_len_q    <= CAP_POS - (ge_n - gs_n);
			out_status_q <= st_n;
		end else if (ctl.respond) begin
			out_char_q   <= rdok_q ? rdata_q : '0;
			out_cursor_q <= gs_q;
			out_len_q    <= len;
			out_status_q <= st_q;
		end
	end

	assign req.ready       = ctl.ready;
	assign rsp.valid       = out_valid_q;
	assign rsp.char_out    = out_char_q;
	assign rsp.cursor      = out_cursor_q;
	assign rsp.text_length = out_len_q;
	assign rsp.status      = out_status_q;

`ifndef SYNTHESIS
	// The gap never inverts
	assert property (@(posedge clk) disable iff (!arst_n)
		gs_q <= ge_q)
		else $error("gap start passed gap end");

	// The gap end stays inside the store
	assert property (@(posedge clk) disable iff (!arst_n)
		ge_q <= CAP_POS)
		else $error("gap end beyond capacity");

	// Each shift step moves both pointers by one, keeping the gap size
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.shift_wr |=> ((ge_q - gs_q) == $past(ge_q - gs_q)) && (gs_q != $past(gs_q)))
		else $error("gap shift step corrupted the gap");
`endif

endmodule

// ----- src/gap_buffer_text_store_unit.sv -----
// Sequence: insert, backspace, delete and unused codes load the response in S_EXEC;
// read looks up in S_EXEC and responds in S_RESP; move sets its target in S_EXEC,
// then moves each byte with a fetch and a store on the single text memory before S_RESP.
// Throughput: one command at a time; the next beat is taken when the previous one retires.
// Reset: arst_n sets the gap to span the store (cursor 0, length 0) and clears the
// response slot; text memory stays undefined and is never read before being written.
module gap_buffer_text_store_unit import gbts_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gbts_in_if.sink    req,
	gbts_out_if.source rsp
);

	ctl_t ctl;
	sts_t sts;

	// Sequencer
	gbts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	// Memory, pointers and response register
	gbts_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts),
		.req    (req),
		.rsp    (rsp)
	);

endmodule
